// File: design/stpq_pkg.sv
// Shared types and status codes for the stable priority queue.
`default_nettype none
package stpq_pkg;

   // Request kinds carried on req_tuser
   localparam logic REQ_ENQUEUE = 1'b0;
   localparam logic REQ_DEQUEUE = 1'b1;

   // Result status codes carried on rsp_tuser
   localparam logic [1:0] ST_ENQUEUED = 2'd0;
   localparam logic [1:0] ST_DEQUEUED = 2'd1;
   localparam logic [1:0] ST_EMPTY    = 2'd2;
   localparam logic [1:0] ST_FULL     = 2'd3;

   localparam int HANDLE_BITS   = 16;
   localparam int OUT_PRIO_BITS = 8;
   localparam int OCC_BITS      = 5;

   // Shift command broadcast to every cell of the chain
   typedef struct packed {
      logic enq;   // insert the new entry, shift the tail right
      logic deq;   // drop the head, shift everything left
   } cell_ctl_type;

endpackage
`default_nettype wire

// File: design/stpq_cell.sv
// One cell of the sorted chain: holds a single entry and trades with its neighbors.
`default_nettype none
module stpq_cell
   import stpq_pkg::*;
#(
   parameter int PRIO_W = 8
) (
   input  wire logic                   clock,
   input  wire cell_ctl_type           ctl,
   input  wire logic                   occ,          // this cell holds a live entry
   input  wire logic [HANDLE_BITS-1:0] new_handle,
   input  wire logic [PRIO_W-1:0]      new_prio,
   input  wire logic                   left_ins,     // left neighbor is at or past the slot
   input  wire logic [HANDLE_BITS-1:0] left_handle,
   input  wire logic [PRIO_W-1:0]      left_prio,
   input  wire logic [HANDLE_BITS-1:0] right_handle,
   input  wire logic [PRIO_W-1:0]      right_prio,
   output      logic                   ins,
   output      logic [HANDLE_BITS-1:0] handle,
   output      logic [PRIO_W-1:0]      prio
);

   logic [HANDLE_BITS-1:0] handle_ff, handle_in;
   logic [PRIO_W-1:0]      prio_ff, prio_in;

   // Strictly greater keeps equal priorities in arrival order
   assign ins = !occ || (prio_ff > new_prio);

   always_comb begin
      handle_in = handle_ff;
      prio_in   = prio_ff;
      if (ctl.enq && ins) begin
         if (left_ins) begin
            handle_in = left_handle;
            prio_in   = left_prio;
         end else begin
            handle_in = new_handle;
            prio_in   = new_prio;
         end
      end else if (ctl.deq) begin
         handle_in = right_handle;
         prio_in   = right_prio;
      end
   end

   always_ff @(posedge clock) begin
      handle_ff <= handle_in;
      prio_ff   <= prio_in;
   end

   assign handle = handle_ff;
   assign prio   = prio_ff;

endmodule
`default_nettype wire

// File: design/stable_priority_queue_top.sv
// Top level of the stable priority queue: cell chain, entry count and result register.
//
// Usage:
//   req channel: req_tuser selects enqueue (0) or dequeue (1); req_tdata carries
//   the task handle and priority of an enqueue. Every request gives exactly one
//   result on the rsp channel: rsp_tuser holds the status, rsp_tdata the dequeued
//   handle and priority (zero otherwise) and the occupancy after the request.
//   Entries sit in a row of cells kept sorted by ascending priority. Each cell
//   compares its own priority with the incoming one in parallel, so the chain
//   takes one request per cycle while the receiver keeps up; the result is
//   registered in the cycle after acceptance.
//   An enqueue into a full queue reports full and is dropped; a dequeue from an
//   empty queue reports empty. Equal priorities leave in arrival order.
//   Reset clears the entry count and the result valid flag; cell contents are
//   left as they are and never read before being written.
//   When the receiver stalls, the result register holds and req_tready drops
//   until the result is taken; a new request is accepted in the same cycle the
//   pending result leaves.
`default_nettype none
module stable_priority_queue_top
   import stpq_pkg::*;
#(
   parameter int QUEUE_DEPTH   = 16,
   parameter int PRIORITY_BITS = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [23:0] req_tdata,   // [15:0] task_handle, [23:16] task_priority
   input  wire logic        req_tuser,   // [0] req_type
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [31:0] rsp_tdata,   // [15:0] out_handle, [23:16] out_priority,
                                         // [28:24] occupancy, rest zero
   output      logic [1:0]  rsp_tuser    // [1:0] status
);

   localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
   localparam int PRIO_EXT  = (PRIORITY_BITS > OUT_PRIO_BITS) ? PRIORITY_BITS : OUT_PRIO_BITS;
   localparam int CNT_EXT   = (CNT_W > OCC_BITS) ? CNT_W : OCC_BITS;
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(QUEUE_DEPTH);

   // Request decode
   logic                     req_fire;
   logic                     is_deq;
   logic [HANDLE_BITS-1:0]   new_handle;
   logic [PRIO_EXT-1:0]      new_prio_ext;
   logic [PRIORITY_BITS-1:0] new_prio;
   logic                     is_full, is_empty;
   cell_ctl_type             ctl;

   // Entry count and result register
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [1:0]             status_ff, status_in;
   logic [HANDLE_BITS-1:0] out_handle_ff, out_handle_in;
   logic [PRIO_EXT-1:0]    out_prio_ff, out_prio_in;
   logic [CNT_EXT-1:0]     occ_ext;

   // Chain wires
   logic [QUEUE_DEPTH-1:0]   cell_ins;
   logic [HANDLE_BITS-1:0]   cell_handle [QUEUE_DEPTH];
   logic [PRIORITY_BITS-1:0] cell_prio   [QUEUE_DEPTH];

   // Accept a request whenever the result register is free or draining
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;
   assign is_deq     = (req_tuser == REQ_DEQUEUE);

   // Keep only the low PRIORITY_BITS of the incoming priority
   assign new_handle   = req_tdata[15:0];
   assign new_prio_ext = PRIO_EXT'(req_tdata[23:16]);
   assign new_prio     = new_prio_ext[PRIORITY_BITS-1:0];

   assign is_full  = (count_ff == FULL_COUNT);
   assign is_empty = (count_ff == '0);

   assign ctl.enq = req_fire && !is_deq && !is_full;
   assign ctl.deq = req_fire && is_deq && !is_empty;

   genvar gi;
   generate
      for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
         logic                     left_ins;
         logic [HANDLE_BITS-1:0]   left_handle, right_handle;
         logic [PRIORITY_BITS-1:0] left_prio, right_prio;

         if (gi == 0) begin : g_head
            // Head has no left neighbor: it takes the new entry directly
            assign left_ins    = 1'b0;
            assign left_handle = new_handle;
            assign left_prio   = new_prio;
         end else begin : g_body
            assign left_ins    = cell_ins[gi-1];
            assign left_handle = cell_handle[gi-1];
            assign left_prio   = cell_prio[gi-1];
         end

         if (gi == QUEUE_DEPTH - 1) begin : g_tail
            // Tail holds its own contents on a dequeue; it falls out of the count
            assign right_handle = cell_handle[gi];
            assign right_prio   = cell_prio[gi];
         end else begin : g_mid
            assign right_handle = cell_handle[gi+1];
            assign right_prio   = cell_prio[gi+1];
         end

         stpq_cell #(
            .PRIO_W(PRIORITY_BITS)
         ) u_cell (
            .clock       (clock),
            .ctl         (ctl),
            .occ         (CNT_W'(gi) < count_ff),
            .new_handle  (new_handle),
            .new_prio    (new_prio),
            .left_ins    (left_ins),
            .left_handle (left_handle),
            .left_prio   (left_prio),
            .right_handle(right_handle),
            .right_prio  (right_prio),
            .ins         (cell_ins[gi]),
            .handle      (cell_handle[gi]),
            .prio        (cell_prio[gi])
         );
      end
   endgenerate

   // Advance the count and load the result on every accepted request
   always_comb begin
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      status_in     = status_ff;
      out_handle_in = out_handle_ff;
      out_prio_in   = out_prio_ff;
      if (req_fire) begin
         rsp_valid_in  = 1'b1;
         out_handle_in = '0;
         out_prio_in   = '0;
         if (!is_deq) begin
            if (is_full) begin
               status_in = ST_FULL;
            end else begin
               status_in = ST_ENQUEUED;
               count_in  = count_ff + CNT_W'(1);
            end
         end else begin
            if (is_empty) begin
               status_in = ST_EMPTY;
            end else begin
               status_in     = ST_DEQUEUED;
               out_handle_in = cell_handle[0];
               out_prio_in   = PRIO_EXT'(cell_prio[0]);
               count_in      = count_ff - CNT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload needs no reset
   always_ff @(posedge clock) begin
      status_ff     <= status_in;
      out_handle_ff <= out_handle_in;
      out_prio_ff   <= out_prio_in;
   end

   assign occ_ext    = CNT_EXT'(count_ff);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = status_ff;
   assign rsp_tdata  = {3'b000, occ_ext[OCC_BITS-1:0], out_prio_ff[OUT_PRIO_BITS-1:0],
                        out_handle_ff};

`ifndef SYNTHESIS
   // Count never passes the number of cells
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("entry count exceeds queue depth");

   // Dequeue of an empty queue reports empty and leaves the count alone
   a_empty_deq: assert property (@(posedge clock) disable iff (reset)
      (req_fire && is_deq && is_empty) |=>
         (rsp_valid_ff && status_ff == ST_EMPTY && count_ff == '0))
      else $error("dequeue on empty queue not reported as empty");

   // Accepted enqueue into a non-full queue grows the count by one
   a_enq_count: assert property (@(posedge clock) disable iff (reset)
      (req_fire && !is_deq && !is_full) |=>
         (count_ff == $past(count_ff) + CNT_W'(1) && status_ff == ST_ENQUEUED))
      else $error("enqueue did not advance the entry count");
`endif

endmodule
`default_nettype wire
